/* design/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg
// Shared constants, codes and controller/datapath interface types for the
// postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

    // stack geometry and operand width
    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // port field widths
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 2;

    // token modes
    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    // how the datapath forms the result of a finished item
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_KEEP,    // stack unchanged, report current top
        EMIT_PUSH,    // push value, report it
        EMIT_COMMIT   // pop two, push result, report it
    } emit_sel_t;

    typedef struct packed {
        logic                latch;      // capture token
        logic                alu;        // add/sub/mul into result register
        logic                div_start;  // launch divider
        logic                load_quot;  // quotient into result register
        emit_sel_t           emit;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              under;
        logic              rhs_zero;
        logic              div_done;
    } dp_stat_t;

endpackage

/* design/postfix_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix (RPN) evaluator over a 16-entry signed 32-bit operand stack.
// ----------------------------------------------------------------------------
// A token (mode, value) is taken when start is high and busy is low. One
// result per token appears on top_value/depth/status for a single cycle with
// done high; there is no back-pressure, so the receiver must capture it then.
// Push, unused modes and all error cases pass through operand read from the
// stack memory, decode/execute and the result cycle, in that order. Add,
// subtract and multiply add a commit step before the result cycle. Divide
// runs through a one-bit-per-cycle divider: operand read, decode, 32
// iterations, sign fix, quotient load, commit and the result cycle. busy
// drops in the cycle done rises, so the next token can be taken at the edge
// that takes the result.
// Underflow, overflow and divide by zero leave the stack untouched and report
// the current top. Subtract and divide take next-below as the left operand.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pse_pkg::MODE_W-1:0]          mode,
    input  logic signed [pse_pkg::VALUE_W-1:0]  value,
    output logic                                done,
    output logic signed [pse_pkg::VALUE_W-1:0]  top_value,
    output logic [pse_pkg::DEPTH_W-1:0]         depth,
    output logic [pse_pkg::STATUS_W-1:0]        status
);
    import pse_pkg::*;

    // controller <-> datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: accept, fetch, decode, wait on divider, commit
    pse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // stack memory, depth counter, alu/divider, result registers
    pse_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .mode      (mode),
        .value     (value),
        .top_value (top_value),
        .depth     (depth),
        .status    (status)
    );

endmodule

/* design/pse_div.sv */
// ----------------------------------------------------------------------------
// pse_div
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pse_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pse_pkg::DATA_W-1:0] dividend,
    input  logic [pse_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [pse_pkg::DATA_W-1:0] quotient
);
    import pse_pkg::*;

    logic                 run_reg, run_next;
    logic                 fix_reg, fix_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    res_reg, res_next;

    logic [DATA_W:0]      rem_sh;
    logic [DATA_W:0]      diff;

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(DATA_W - 1);
            rem_next = '0;
            quo_next = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dvs_next = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (run_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
                fix_next = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            res_next  = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

/* design/pse_datapath.sv */
// ----------------------------------------------------------------------------
// pse_datapath
// Operand stack memory, depth counter, arithmetic and result registers.
// ----------------------------------------------------------------------------
module pse_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pse_pkg::dp_cmd_t             cmd,
    output pse_pkg::dp_stat_t            stat,
    input  logic [pse_pkg::MODE_W-1:0]   mode,
    input  logic signed [pse_pkg::VALUE_W-1:0] value,
    output logic signed [pse_pkg::VALUE_W-1:0] top_value,
    output logic [pse_pkg::DEPTH_W-1:0]  depth,
    output logic [pse_pkg::STATUS_W-1:0] status
);
    import pse_pkg::*;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    logic [CNT_W-1:0]           count_reg, count_next;
    logic [MODE_W-1:0]          mode_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic [DATA_W-1:0]          rd_top_reg;
    logic [DATA_W-1:0]          rd_nos_reg;
    logic [DATA_W-1:0]          res_reg, res_next;
    logic signed [VALUE_W-1:0]  top_value_reg, top_value_next;
    logic [DEPTH_W-1:0]         depth_reg, depth_next;
    logic [STATUS_W-1:0]        status_reg, status_next;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [PTR_W-1:0]  addr_top;
    logic [PTR_W-1:0]  addr_nos;
    logic [PTR_W-1:0]  wr_addr;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] push_data;
    logic              div_done;
    logic [DATA_W-1:0] quotient;

    assign cnt_m1    = count_reg - 1'b1;
    assign cnt_m2    = count_reg - 2'd2;
    assign addr_top  = cnt_m1[PTR_W-1:0];
    assign addr_nos  = cnt_m2[PTR_W-1:0];
    assign push_data = DATA_W'(value_reg);

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_nos_reg),
        .divisor  (rd_top_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // result register: alu op or divider quotient
    always_comb
    begin
        res_next = res_reg;
        if (cmd.alu)
        begin
            case (mode_reg)
                MODE_ADD: res_next = rd_nos_reg + rd_top_reg;
                MODE_SUB: res_next = rd_nos_reg - rd_top_reg;
                default:  res_next = DATA_W'(rd_nos_reg * rd_top_reg);
            endcase
        end
        else if (cmd.load_quot)
        begin
            res_next = quotient;
        end
    end

    // stack write, depth update and reported result
    always_comb
    begin
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_nos;
        wr_data        = res_reg;
        top_value_next = top_value_reg;
        depth_next     = depth_reg;
        status_next    = status_reg;
        unique case (cmd.emit)
            EMIT_KEEP:
            begin
                top_value_next = (count_reg != '0) ? VALUE_W'(rd_top_reg) : '0;
                depth_next     = DEPTH_W'(count_reg);
                status_next    = cmd.status;
            end
            EMIT_PUSH:
            begin
                wr_en          = 1'b1;
                wr_addr        = count_reg[PTR_W-1:0];
                wr_data        = push_data;
                count_next     = count_reg + 1'b1;
                top_value_next = VALUE_W'(push_data);
                depth_next     = DEPTH_W'(count_next);
                status_next    = cmd.status;
            end
            EMIT_COMMIT:
            begin
                wr_en          = 1'b1;
                count_next     = cnt_m1;
                top_value_next = VALUE_W'(res_reg);
                depth_next     = DEPTH_W'(cnt_m1);
                status_next    = cmd.status;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
        res_reg       <= res_next;
        top_value_reg <= top_value_next;
        depth_reg     <= depth_next;
        status_reg    <= status_next;
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_top_reg <= stack_mem[addr_top];
        rd_nos_reg <= stack_mem[addr_nos];
    end

    assign stat.mode     = mode_reg;
    assign stat.full     = (count_reg >= CNT_W'(STACK_DEPTH));
    assign stat.under    = (count_reg < CNT_W'(2));
    assign stat.rhs_zero = (rd_top_reg == '0);
    assign stat.div_done = div_done;

    assign top_value = top_value_reg;
    assign depth     = depth_reg;
    assign status    = status_reg;

endmodule

/* design/pse_ctrl.sv */
// ----------------------------------------------------------------------------
// pse_ctrl
// Token sequencer: operand fetch, decode, divider wait and commit.
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output pse_pkg::dp_cmd_t  cmd,
    input  pse_pkg::dp_stat_t stat
);
    import pse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIVW,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{latch: 1'b0, alu: 1'b0, div_start: 1'b0, load_quot: 1'b0,
                       emit: EMIT_NONE, status: ST_OK};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // operand reads land at the end of this cycle
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (stat.mode) inside
                    MODE_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.emit   = EMIT_KEEP;
                            cmd.status = ST_OVER;
                        end
                        else
                        begin
                            cmd.emit = EMIT_PUSH;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL:
                    begin
                        if (stat.under)
                        begin
                            cmd.emit   = EMIT_KEEP;
                            cmd.status = ST_UNDER;
                        end
                        else
                        begin
                            cmd.alu    = 1'b1;
                            state_next = S_COMMIT;
                        end
                    end
                    MODE_DIV:
                    begin
                        if (stat.under)
                        begin
                            cmd.emit   = EMIT_KEEP;
                            cmd.status = ST_UNDER;
                        end
                        else if (stat.rhs_zero)
                        begin
                            cmd.emit   = EMIT_KEEP;
                            cmd.status = ST_DIVZ;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIVW;
                        end
                    end
                    default:
                    begin
                        // unused mode: no stack change
                        cmd.emit = EMIT_KEEP;
                    end
                endcase
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    cmd.load_quot = 1'b1;
                    state_next    = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.emit   = EMIT_COMMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (cmd.emit != EMIT_NONE);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

/* design/pse_checker.sv */
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks on the postfix stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pse_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic signed [pse_pkg::VALUE_W-1:0]  top_value,
    input logic [pse_pkg::DEPTH_W-1:0]         depth,
    input logic [pse_pkg::STATUS_W-1:0]        status
);
    import pse_pkg::*;

    // an accepted token holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // result strobe is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // overflow only reported on a full stack
    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OVER |-> depth == DEPTH_W'(STACK_DEPTH))
        else $error("overflow reported on non-full stack");

    // underflow only reported below two entries
    a_under_depth: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_UNDER |-> depth < DEPTH_W'(2))
        else $error("underflow reported with two or more entries");

    // empty stack reports zero top
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        done && depth == '0 |-> top_value == '0)
        else $error("nonzero top on empty stack");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the postfix stack evaluator: drives push and
// operator tokens through the start/busy handshake, keeps its own copy of the
// operand stack, and compares every done strobe against the predicted top,
// depth and status.
// ----------------------------------------------------------------------------
module testbench;

    import pse_pkg::*;

    // spare mode codes; the block ignores these but still answers each one
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_DIV + 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

    // operand corner values
    localparam logic [VALUE_W-1:0] VAL_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] VAL_MAX  = ~VAL_MIN;
    localparam logic [VALUE_W-1:0] VAL_NEG1 = '1;
    localparam logic [VALUE_W-1:0] VAL_ONE  = 1;

    // items per random phase (three phases of sender idling)
    localparam int unsigned PHASE_ITEMS = 570;
    // cycles to keep watching after the last result, well past a divide
    localparam int unsigned DRAIN_CYCLES = 80;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic [DEPTH_W-1:0]        depth;
        logic [STATUS_W-1:0]       status;
    } stack_result_t;

    // ------------------------------------------------------------------------
    // Stack shadow and result checker. note_token() runs the token against
    // the shadow stack when the block accepts it; check_result() compares a
    // done strobe with the oldest outstanding prediction.
    // ------------------------------------------------------------------------
    class stack_scoreboard;
        logic [DATA_W-1:0] operands [STACK_DEPTH];
        int unsigned       count;
        stack_result_t     pending_q [$];
        int unsigned       errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // signed divide, truncating toward zero; MIN / -1 wraps to MIN
        function logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] lhs,
                                                   input logic [DATA_W-1:0] rhs);
            logic [DATA_W-1:0] mag_l;
            logic [DATA_W-1:0] mag_r;
            logic [DATA_W-1:0] quot;
            mag_l = lhs[DATA_W-1] ? -lhs : lhs;
            mag_r = rhs[DATA_W-1] ? -rhs : rhs;
            quot  = mag_l / mag_r;
            if (lhs[DATA_W-1] ^ rhs[DATA_W-1])
                quot = -quot;
            return quot;
        endfunction

        function void note_token(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
            stack_result_t       want;
            logic [DATA_W-1:0]   lhs;
            logic [DATA_W-1:0]   rhs;
            logic [DATA_W-1:0]   res;
            logic [STATUS_W-1:0] st;
            st  = ST_OK;
            res = '0;
            if (m == MODE_PUSH)
            begin
                if (count >= STACK_DEPTH)
                    st = ST_OVER;
                else
                begin
                    operands[count] = v;
                    count++;
                end
            end
            else if (m <= MODE_DIV)
            begin
                if (count < 2)
                    st = ST_UNDER;
                else
                begin
                    rhs = operands[count-1];
                    lhs = operands[count-2];
                    case (m)
                        MODE_ADD: res = lhs + rhs;
                        MODE_SUB: res = lhs - rhs;
                        MODE_MUL: res = lhs * rhs;
                        default:
                        begin
                            if (rhs == '0)
                                st = ST_DIVZ;
                            else
                                res = trunc_quotient(lhs, rhs);
                        end
                    endcase
                    if (st == ST_OK)
                    begin
                        count--;
                        operands[count-1] = res;
                    end
                end
            end
            want.top_value = (count > 0) ? operands[count-1] : '0;
            want.depth     = DEPTH_W'(count);
            want.status    = st;
            pending_q      = {pending_q, want};
        endfunction

        function void check_result(input logic [VALUE_W-1:0] top, input logic [DEPTH_W-1:0] dep,
                                   input logic [STATUS_W-1:0] st);
            stack_result_t want;
            if (pending_q.size() == 0)
            begin
                $error("result with no token outstanding: top_value %0d depth %0d status %0d",
                       $signed(top), dep, st);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (top !== want.top_value)
            begin
                $error("top_value: expected %0d, actual %0d", want.top_value, $signed(top));
                errors++;
            end
            if (dep !== want.depth)
            begin
                $error("depth: expected %0d, actual %0d", want.depth, dep);
                errors++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs; all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                        clk   = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [MODE_W-1:0]           mode  = MODE_PUSH;
    logic [VALUE_W-1:0]          value = '0;
    logic                        busy;
    logic                        done;
    logic signed [VALUE_W-1:0]   top_value;
    logic [DEPTH_W-1:0]          depth;
    logic [STATUS_W-1:0]         status;

    stack_scoreboard sb = new();

    // percent chance, per cycle, that the sender holds off after an item
    int unsigned sender_idle_pct = 27;

    always #4 clk = ~clk;

    postfix_stack_evaluator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .value     (value),
        .done      (done),
        .top_value (top_value),
        .depth     (depth),
        .status    (status)
    );

    // Results can't be held off, so every done cycle is checked. Outputs are
    // read at the edge before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(top_value, depth, status);
    end

    // ------------------------------------------------------------------------
    // Token driver. start/mode/value go out on a rising edge and the item is
    // taken at the first later edge that sees busy low. After acceptance the
    // sender may hold off a random number of cycles; when it does, start drops
    // in the acceptance step and mode/value get junk, so each input sees at
    // most one update per step.
    // ------------------------------------------------------------------------
    task automatic issue_token(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
        int unsigned gap;
        start <= 1'b1;
        mode  <= m;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_token(m, v);
        gap = 0;
        while (gap < 20 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            mode  <= MODE_W'($urandom);
            value <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    // corner values often, small magnitudes for readable divides, else anything
    function automatic logic [VALUE_W-1:0] random_operand();
        logic [VALUE_W-1:0] mag;
        case ($urandom_range(9))
            0: return '0;
            1: return VAL_ONE;
            2: return VAL_NEG1;
            3: return VAL_MIN;
            4: return VAL_MAX;
            5, 6:
            begin
                mag = $urandom_range(1, 300);
                return $urandom_range(1) ? -mag : mag;
            end
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed expression traffic: alternating fill and drain runs
    // so the stack swings between empty and full. A slice of the tokens is
    // noise: spare modes, operators at any depth, pushes onto a full stack.
    task automatic random_tokens(input int unsigned n_items);
        int unsigned       counted;
        int unsigned       run_left;
        bit                filling;
        int unsigned       pick;
        logic [MODE_W-1:0] m;
        counted  = 0;
        filling  = 1'b1;
        run_left = $urandom_range(10, 40);
        while (counted < n_items)
        begin
            if (run_left == 0)
            begin
                filling  = !filling;
                run_left = $urandom_range(10, 40);
            end
            run_left--;
            pick = $urandom_range(99);
            if (pick < 4)
                m = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            else if (pick < 10)
                m = MODE_W'($urandom_range(MODE_PUSH, MODE_DIV));
            else if (sb.count < 2)
                m = MODE_PUSH;
            else if (sb.count >= STACK_DEPTH)
                m = ($urandom_range(3) == 0) ? MODE_PUSH
                                             : MODE_W'($urandom_range(MODE_ADD, MODE_DIV));
            else if ($urandom_range(99) < (filling ? 80 : 25))
                m = MODE_PUSH;
            else
                m = MODE_W'($urandom_range(MODE_ADD, MODE_DIV));
            issue_token(m, random_operand());
            if (m <= MODE_DIV)
                counted++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        issue_token(MODE_ADD, '0);          // operator on empty stack: underflow
        issue_token(MODE_PUSH, VAL_MAX);
        issue_token(MODE_DIV, '0);          // one entry only: underflow
        issue_token(MODE_PUSH, VAL_ONE);
        issue_token(MODE_ADD, '0);          // MAX + 1 wraps to MIN
        issue_token(MODE_PUSH, VAL_NEG1);
        issue_token(MODE_DIV, '0);          // MIN / -1 wraps back to MIN
        issue_token(MODE_PUSH, '0);
        issue_token(MODE_DIV, '0);          // divide by zero, stack untouched
        issue_token(MODE_SUB, '0);          // next-below minus top
        issue_token(MODE_SPARE_LAST, VAL_MAX);
        issue_token(MODE_SPARE_FIRST, VAL_MIN);
        for (int i = 0; i < 13; i++)
            issue_token(MODE_PUSH, (i % 2) ? ~(VAL_ONE << (2 * i)) : (VAL_ONE << (2 * i + 1)));
        issue_token(MODE_PUSH, -32'sd7);
        issue_token(MODE_PUSH, 32'sd2);     // stack now full
        issue_token(MODE_PUSH, VAL_MAX);    // overflow
        issue_token(MODE_DIV, '0);          // -7 / 2 truncates to -3
        issue_token(MODE_MUL, '0);

        // random traffic under three sender idling profiles
        random_tokens(PHASE_ITEMS);
        sender_idle_pct = 66;
        random_tokens(PHASE_ITEMS);
        sender_idle_pct = 0;
        random_tokens(PHASE_ITEMS);
        start <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hard stop: several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
